### rtl/core/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and codes of the linear probing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package lph_pkg;

    localparam int SLOTS_DEF = 1024;
    localparam int CNT_W     = 11;
    localparam int HASH_W    = 64;
    localparam int GRP_W     = 32;
    localparam int VAL_W     = 64;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;

    localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FIND      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLR_ALL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLR_GROUP = 3'd4;

    localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FAILED  = 2'd3;

    localparam logic [1:0] SLOT_UNUSED   = 2'd0;
    localparam logic [1:0] SLOT_DELETED  = 2'd1;
    localparam logic [1:0] SLOT_OCCUPIED = 2'd2;

    localparam logic [CNT_W-1:0] MAX_RESET = 11'd1024;

    typedef struct packed {
        logic [1:0]        state;
        logic [HASH_W-1:0] hash;
        logic [GRP_W-1:0]  group;
        logic [VAL_W-1:0]  value;
    } t_entry;

endpackage

`default_nettype wire

### rtl/core/lph_if.sv
// ----------------------------------------------------------------------------
// lph_if
// Channel interfaces: command items, result items, load limit writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lph_req_if;
    logic                        valid;
    logic                        ready;
    logic [lph_pkg::CMD_W-1:0]   cmd;
    logic [lph_pkg::HASH_W-1:0]  key_hash;
    logic [lph_pkg::GRP_W-1:0]   group_tag;
    logic [lph_pkg::VAL_W-1:0]   write_value;
    modport source (output valid, cmd, key_hash, group_tag, write_value, input ready);
    modport sink   (input valid, cmd, key_hash, group_tag, write_value, output ready);
endinterface

interface lph_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [lph_pkg::VAL_W-1:0]   read_value;
    logic [lph_pkg::STAT_W-1:0]  status;
    logic [lph_pkg::CNT_W-1:0]   live_count;
    modport source (output valid, found, read_value, status, live_count, input ready);
    modport sink   (input valid, found, read_value, status, live_count, output ready);
endinterface

interface lph_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lph_pkg::CNT_W-1:0]   max_entries;
    modport source (output valid, max_entries, input ready);
    modport sink   (input valid, max_entries, output ready);
endinterface

`default_nettype wire

### rtl/core/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing table with linear probing and tombstones in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one command item (write, find, erase, clear all, clear
//   group); o_rsp returns exactly one result item for each. i_cfg writes the
//   load limit and is always ready; write it only while the block is idle.
//   An item is taken only while the sequencer is idle, one at a time.
//   Each item passes an accept step, a probe over the slots from its home
//   slot, and a result step. A write that reuses a foreign tombstone
//   walks a second probe from home plus a write step. Clear all and clear
//   group sweep every slot. A refused, failed or trivial command goes from
//   the accept step straight to the result step. The probe and the sweep
//   are paced by the single read port of the slot memory, one slot per cycle.
//   After reset the block sweeps the memory marking every slot unused; no
//   item is taken meanwhile (load limit writes are).
//   The result sits in an output register; a stalled receiver holds it and
//   the next item may already be accepted and worked on, but it finishes
//   only once the register has been drained.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table #(
    parameter int SLOTS = lph_pkg::SLOTS_DEF
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    lph_req_if.sink   i_req,
    lph_rsp_if.source o_rsp,
    lph_cfg_if.sink   i_cfg
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [lph_pkg::CNT_W-1:0] t_cnt;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PROBE  = 6'b000010,
        ST_PROBE2 = 6'b000100,
        ST_WRITE2 = 6'b001000,
        ST_SWEEP  = 6'b010000,
        ST_FINISH = 6'b100000
    } t_state;

    lph_pkg::t_entry mem [SLOTS];
    lph_pkg::t_entry r_rdata;
    logic            mem_we;
    t_idx            mem_wa, mem_ra;
    lph_pkg::t_entry mem_wd;

    t_state                       r_state, n_state;
    logic [lph_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [lph_pkg::HASH_W-1:0]   r_hash, n_hash;
    logic [lph_pkg::GRP_W-1:0]    r_grp, n_grp;
    logic [lph_pkg::VAL_W-1:0]    r_val, n_val;
    t_idx                         r_home, n_home, r_cur, n_cur, r_slot, n_slot;
    t_cnt                         r_count, n_count, r_max;
    logic                         r_failed, n_failed, r_init, n_init;
    logic                         r_found, n_found;
    logic [lph_pkg::VAL_W-1:0]    r_rval, n_rval;
    logic [lph_pkg::STAT_W-1:0]   r_status, n_status;
    logic                         r_ovalid, n_ovalid;
    logic                         r_ofound;
    logic [lph_pkg::VAL_W-1:0]    r_orval;
    logic [lph_pkg::STAT_W-1:0]   r_ostatus;
    t_cnt                         r_ocount;

    t_idx            cur_nx, home_in;
    logic            wrap, stop1, stop2, out_free, load_out;
    lph_pkg::t_entry new_ent, del_ent;

    assign cur_nx   = r_cur + t_idx'(1);
    assign wrap     = (cur_nx == r_home);
    assign home_in  = i_req.key_hash[IDX_W-1:0];
    assign out_free = !r_ovalid || o_rsp.ready;
    assign load_out = (r_state == ST_FINISH) && out_free;

    // write probe stops on unused, tombstone or matching hash
    assign stop1 = (r_rdata.state <= lph_pkg::SLOT_DELETED) || (r_rdata.hash == r_hash);
    assign stop2 = (r_rdata.state == lph_pkg::SLOT_UNUSED) || (r_rdata.hash == r_hash);

    assign new_ent = '{state: lph_pkg::SLOT_OCCUPIED, hash: r_hash, group: r_grp,
                       value: r_val};
    always_comb begin
        del_ent       = r_rdata;
        del_ent.state = lph_pkg::SLOT_DELETED;
    end

    assign i_req.ready       = (r_state == ST_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.found       = r_ofound;
    assign o_rsp.read_value  = r_orval;
    assign o_rsp.status      = r_ostatus;
    assign o_rsp.live_count  = r_ocount;

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_hash   = r_hash;
        n_grp    = r_grp;
        n_val    = r_val;
        n_home   = r_home;
        n_cur    = cur_nx;
        n_slot   = r_slot;
        n_count  = r_count;
        n_failed = r_failed;
        n_init   = r_init;
        n_found  = r_found;
        n_rval   = r_rval;
        n_status = r_status;
        mem_we   = 1'b0;
        mem_wa   = r_cur;
        mem_wd   = del_ent;
        mem_ra   = cur_nx;

        unique case (r_state)
            ST_IDLE: begin
                mem_ra = home_in;
                n_cur  = r_cur;
                if (i_req.valid) begin
                    n_cmd    = i_req.cmd;
                    n_hash   = i_req.key_hash;
                    n_grp    = i_req.group_tag;
                    n_val    = i_req.write_value;
                    n_home   = home_in;
                    n_cur    = home_in;
                    n_found  = 1'b0;
                    n_rval   = '0;
                    n_status = lph_pkg::STAT_DONE;
                    n_state  = ST_FINISH;
                    if (r_failed) begin
                        n_status = lph_pkg::STAT_FAILED;
                    end else begin
                        case (i_req.cmd)
                            lph_pkg::CMD_WRITE: begin
                                if (r_count >= r_max) n_status = lph_pkg::STAT_REFUSED;
                                else                  n_state  = ST_PROBE;
                            end
                            lph_pkg::CMD_FIND, lph_pkg::CMD_ERASE: begin
                                if (r_count == '0) n_status = lph_pkg::STAT_MISS;
                                else               n_state  = ST_PROBE;
                            end
                            lph_pkg::CMD_CLR_ALL: n_state = ST_SWEEP;
                            lph_pkg::CMD_CLR_GROUP: begin
                                if (r_count != '0) n_state = ST_SWEEP;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ST_PROBE: begin
                if (r_cmd == lph_pkg::CMD_WRITE) begin
                    if (stop1) begin
                        n_state = ST_FINISH;
                        mem_we  = 1'b1;
                        if (r_rdata.state == lph_pkg::SLOT_OCCUPIED) begin
                            mem_wd       = r_rdata;
                            mem_wd.value = r_val;
                        end else if (r_rdata.state == lph_pkg::SLOT_DELETED &&
                                     r_rdata.hash != r_hash) begin
                            // foreign tombstone: look for a later duplicate first
                            mem_we  = 1'b0;
                            n_slot  = r_cur;
                            mem_ra  = r_home;
                            n_cur   = r_home;
                            n_state = ST_PROBE2;
                        end else begin
                            mem_wd  = new_ent;
                            n_count = r_count + t_cnt'(1);
                        end
                    end else if (wrap) begin
                        n_failed = 1'b1;
                        n_status = lph_pkg::STAT_FAILED;
                        n_state  = ST_FINISH;
                    end
                end else begin
                    if (stop2) begin
                        n_state = ST_FINISH;
                        if (r_rdata.state == lph_pkg::SLOT_OCCUPIED) begin
                            if (r_cmd == lph_pkg::CMD_FIND) begin
                                n_found = 1'b1;
                                n_rval  = r_rdata.value;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count - t_cnt'(1);
                            end
                        end else begin
                            n_status = lph_pkg::STAT_MISS;
                        end
                    end else if (wrap) begin
                        n_status = lph_pkg::STAT_MISS;
                        n_state  = ST_FINISH;
                    end
                end
            end
            ST_PROBE2: begin
                if (stop2 || wrap) n_state = ST_WRITE2;
                if (stop2 && r_rdata.state == lph_pkg::SLOT_OCCUPIED) begin
                    mem_we  = 1'b1;
                    n_count = r_count - t_cnt'(1);
                end
            end
            ST_WRITE2: begin
                mem_we  = 1'b1;
                mem_wa  = r_slot;
                mem_wd  = new_ent;
                n_count = r_count + t_cnt'(1);
                n_state = ST_FINISH;
            end
            ST_SWEEP: begin
                if (r_cmd == lph_pkg::CMD_CLR_ALL) begin
                    mem_we = 1'b1;
                    mem_wd = '0;
                end else if (r_rdata.state == lph_pkg::SLOT_OCCUPIED &&
                             r_rdata.group == r_grp) begin
                    mem_we  = 1'b1;
                    n_count = n_count - t_cnt'(1);
                end
                if (wrap) begin
                    if (r_cmd == lph_pkg::CMD_CLR_ALL) n_count = '0;
                    n_init  = 1'b0;
                    n_state = r_init ? ST_IDLE : ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_cur  = r_cur;
                mem_ra = r_cur;
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (load_out)          n_ovalid = 1'b1;
        else if (o_rsp.ready)  n_ovalid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_SWEEP;
            r_cmd    <= lph_pkg::CMD_CLR_ALL;
            r_home   <= '0;
            r_cur    <= '0;
            r_count  <= '0;
            r_failed <= 1'b0;
            r_init   <= 1'b1;
            r_max    <= lph_pkg::MAX_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cmd    <= n_cmd;
            r_home   <= n_home;
            r_cur    <= n_cur;
            r_count  <= n_count;
            r_failed <= n_failed;
            r_init   <= n_init;
            r_ovalid <= n_ovalid;
            if (i_cfg.valid) r_max <= i_cfg.max_entries;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash   <= n_hash;
        r_grp    <= n_grp;
        r_val    <= n_val;
        r_slot   <= n_slot;
        r_found  <= n_found;
        r_rval   <= n_rval;
        r_status <= n_status;
        if (load_out) begin
            r_ofound  <= r_found;
            r_orval   <= r_rval;
            r_ostatus <= r_status;
            r_ocount  <= r_count;
        end
    end

    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= SLOTS)
        else $error("live count above capacity");

    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |=> r_failed)
        else $error("failure flag dropped");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == ST_FINISH))
        else $error("result item without a finished command");

    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !i_req.ready)
        else $error("item accepted during clearing pass");

endmodule

`default_nettype wire
